// File: rtl/bbh_pkg.sv
`default_nettype none

package bbh_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned CONTEXTS_DEF       = 4;
	localparam int unsigned BYTES_PER_ITEM_DEF = 8;
	localparam int unsigned COUNT_BITS_DEF     = 32;

	// Fixed field geometry
	localparam int unsigned LANE_BITS  = 8;
	localparam int unsigned KEY_BITS   = 16;
	localparam int unsigned TOTAL_BITS = 32;
	localparam logic [TOTAL_BITS-1:0] REPORT_RESET = 32'd80;

	typedef enum logic [0:0] {
		OP_RECORD = 1'b0,
		OP_READ   = 1'b1
	} opcode_t;

	// Request to the counter memory
	typedef struct packed {
		logic rd_en;    // read the addressed bin this cycle
		logic bump;     // increment and write it back next cycle
	} mem_req_t;

	// Status from the counter memory
	typedef struct packed {
		logic clearing; // reset sweep still running
	} mem_stat_t;

endpackage

`default_nettype wire

// File: rtl/bbh_if.sv
`default_nettype none

interface bbh_req_if;
	logic             valid;
	logic             ready;
	bbh_pkg::opcode_t opcode;
	logic [1:0]       context_req;
	logic [3:0]       byte_count;
	logic [63:0]      data_bytes;
	logic [15:0]      bigram_key;

	modport source (output valid, opcode, context_req, byte_count, data_bytes, bigram_key,
		input ready);
	modport sink (input valid, opcode, context_req, byte_count, data_bytes, bigram_key,
		output ready);
endinterface

interface bbh_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] bigram_count;
	logic [31:0] context_bytes;
	logic        reportable;

	modport source (output valid, bigram_count, context_bytes, reportable, input ready);
	modport sink (input valid, bigram_count, context_bytes, reportable, output ready);
endinterface

interface bbh_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/byte_bigram_histogram.sv
`default_nettype none

// Channel  Dir  Beat
// req      in   opcode, context_req, byte_count, data_bytes, bigram_key
// rsp      out  bigram_count, context_bytes, reportable
// cfg      in   report_min_bytes write data
//
// One item at a time. A record is accepted, then takes one data byte per
// cycle (one bin read-modify-write per cycle on the single counter memory),
// then posts the result; a read is accepted, reads its bin, then posts.
// After reset the counter memory is swept clear, all CONTEXTS * 65536 bins,
// with req.ready low; cfg writes are taken at all times.
// The result sits in an output register, so rsp stalls hold only the next
// item's final cycle.
module byte_bigram_histogram #(
	parameter int unsigned CONTEXTS       = bbh_pkg::CONTEXTS_DEF,
	parameter int unsigned BYTES_PER_ITEM = bbh_pkg::BYTES_PER_ITEM_DEF,
	parameter int unsigned COUNT_BITS     = bbh_pkg::COUNT_BITS_DEF
) (
	input  wire      clk,
	input  wire      arst_n,
	bbh_req_if.sink  req,
	bbh_rsp_if.source rsp,
	bbh_cfg_if.sink  cfg
);
	import bbh_pkg::*;

	localparam int unsigned CTX_W  = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
	localparam int unsigned ADDR_W = CTX_W + KEY_BITS;
	localparam int unsigned IDX_W  = (BYTES_PER_ITEM > 1) ? $clog2(BYTES_PER_ITEM) : 1;
	localparam logic [3:0]  MAX_CNT = 4'(BYTES_PER_ITEM);
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RECORD,
		ST_READ,
		ST_FINISH
	} state_t;

	state_t                state_q;

	// Item held while it is worked on
	opcode_t               op_q;
	logic                  bad_q;
	logic [CTX_W-1:0]      ctx_q;
	logic [3:0]            cnt_q;
	logic [63:0]           data_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [IDX_W-1:0]      idx_q;

	// Per-context state
	logic                  started_q [CONTEXTS];
	logic [LANE_BITS-1:0]  prev_q    [CONTEXTS];
	logic [TOTAL_BITS-1:0] total_q   [CONTEXTS];

	logic [TOTAL_BITS-1:0] report_q;

	// Output register
	logic                  out_vld_q;
	logic [31:0]           out_count_q;
	logic [31:0]           out_bytes_q;
	logic                  out_rep_q;

	mem_req_t              mreq;
	mem_stat_t             mstat;
	logic [ADDR_W-1:0]     maddr;
	logic [COUNT_BITS-1:0] mdata;

	logic [LANE_BITS-1:0]  cur_byte;
	logic                  last_byte;
	logic [3:0]            in_cnt;
	logic                  in_bad;
	logic                  out_free;

	bbh_count_mem #(
		.CONTEXTS   (CONTEXTS),
		.COUNT_BITS (COUNT_BITS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.addr    (maddr),
		.rd_data (mdata),
		.stat    (mstat)
	);

	// Pick the lane and the memory access for this cycle
	always_comb begin
		cur_byte   = data_q[idx_q*LANE_BITS +: LANE_BITS];
		last_byte  = (4'(idx_q) + 4'd1 == cnt_q);
		mreq.rd_en = 1'b0;
		mreq.bump  = 1'b0;
		maddr      = {ctx_q, key_q};
		if (state_q == ST_RECORD) begin
			mreq.rd_en = started_q[ctx_q];
			mreq.bump  = 1'b1;
			maddr      = {ctx_q, prev_q[ctx_q], cur_byte};
		end else if (state_q == ST_READ) begin
			mreq.rd_en = 1'b1;
		end
	end

	// Clamp the byte count, check the context on the incoming beat, and see if the output register is free
	always_comb begin
		in_cnt   = (req.byte_count > MAX_CNT) ? MAX_CNT : req.byte_count;
		in_bad   = (32'(req.context_req) >= CONTEXTS);
		out_free = !out_vld_q || rsp.ready;
	end

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			report_q  <= REPORT_RESET;
			out_vld_q <= 1'b0;
			for (int c = 0; c < CONTEXTS; c++) begin
				started_q[c] <= 1'b0;
				prev_q[c]    <= '0;
				total_q[c]   <= '0;
			end
		end else begin
			if (cfg.valid) begin
				report_q <= cfg.data;
			end
			// Raise the result when posted, drop it once taken
			if (state_q == ST_FINISH && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (!mstat.clearing) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						if (in_bad || (req.opcode == OP_RECORD && in_cnt == 4'd0)) begin
							state_q <= ST_FINISH;
						end else if (req.opcode == OP_READ) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_RECORD;
						end
					end
				end
				ST_RECORD: begin
					// Advance one byte: prime or bump, then count it
					started_q[ctx_q] <= 1'b1;
					prev_q[ctx_q]    <= cur_byte;
					if (total_q[ctx_q] != TOTAL_MAX) begin
						total_q[ctx_q] <= total_q[ctx_q] + 1'b1;
					end
					if (last_byte) begin
						state_q <= ST_FINISH;
					end
				end
				ST_READ: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// Post the result when the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			op_q   <= req.opcode;
			bad_q  <= in_bad;
			ctx_q  <= CTX_W'(req.context_req);
			cnt_q  <= in_cnt;
			data_q <= req.data_bytes;
			key_q  <= req.bigram_key;
			idx_q  <= '0;
		end else if (state_q == ST_RECORD) begin
			idx_q <= idx_q + 1'b1;
		end
		if (state_q == ST_FINISH && out_free) begin
			if (bad_q) begin
				out_count_q <= '0;
				out_bytes_q <= '0;
				out_rep_q   <= 1'b0;
			end else begin
				out_count_q <= (op_q == OP_READ) ? 32'(mdata) : 32'd0;
				out_bytes_q <= total_q[ctx_q];
				out_rep_q   <= (total_q[ctx_q] >= report_q);
			end
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.bigram_count  = out_count_q;
	assign rsp.context_bytes = out_bytes_q;
	assign rsp.reportable    = out_rep_q;

endmodule

`default_nettype wire

// File: rtl/bbh_count_mem.sv
`default_nettype none

module bbh_count_mem #(
	parameter int unsigned CONTEXTS   = bbh_pkg::CONTEXTS_DEF,
	parameter int unsigned COUNT_BITS = bbh_pkg::COUNT_BITS_DEF,
	localparam int unsigned CTX_W  = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1,
	localparam int unsigned ADDR_W = CTX_W + bbh_pkg::KEY_BITS
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire bbh_pkg::mem_req_t       req,
	input  wire         [ADDR_W-1:0]     addr,
	output logic        [COUNT_BITS-1:0] rd_data,
	output bbh_pkg::mem_stat_t           stat
);
	import bbh_pkg::*;

	localparam int unsigned DEPTH = CONTEXTS * (1 << KEY_BITS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [COUNT_BITS-1:0] mem [0:DEPTH-1];
	logic [COUNT_BITS-1:0] rd_q;

	logic                  clearing_q;
	logic [ADDR_W-1:0]     clr_addr_q;

	logic                  bump_s1;
	logic [ADDR_W-1:0]     addr_s1;

	logic                  wr_vld_q;
	logic [ADDR_W-1:0]     wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;

	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] nxt;
	logic                  we;
	logic [ADDR_W-1:0]     wa;
	logic [COUNT_BITS-1:0] wd;

	// Forward the previous write when the bin was read before it landed
	always_comb begin
		cur = (wr_vld_q && wr_addr_q == addr_s1) ? wr_data_q : rd_q;
		nxt = (cur == COUNT_MAX) ? cur : cur + 1'b1;
	end

	// Write port: reset sweep has the port to itself, then increments
	always_comb begin
		we = clearing_q || bump_s1;
		wa = clearing_q ? clr_addr_q : addr_s1;
		wd = clearing_q ? '0 : nxt;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (req.rd_en) begin
			rd_q <= mem[addr];
		end
	end

	// Clear sweep and increment stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			bump_s1    <= 1'b0;
			wr_vld_q   <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					clearing_q <= 1'b0;
				end
			end
			bump_s1  <= req.rd_en && req.bump;
			wr_vld_q <= bump_s1;
		end
	end

	// Hold address of the bin in flight and the last value written
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			addr_s1 <= addr;
		end
		if (bump_s1) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= nxt;
		end
	end

	assign rd_data       = rd_q;
	assign stat.clearing = clearing_q;

endmodule

`default_nettype wire

// File: tb/tb_byte_bigram_histogram.sv
`default_nettype none

module tb_byte_bigram_histogram;
	import bbh_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Covers the clearing sweep of all 262144 bins after reset several times over
	localparam int unsigned QUIET_LIMIT = 1_000_000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam logic [31:0] BIN_MAX = 32'hFFFF_FFFF >> (32 - COUNT_BITS_DEF);

	typedef struct packed {
		opcode_t     op;
		logic [1:0]  ctx;
		logic [3:0]  nbytes;
		logic [63:0] data;
		logic [15:0] key;
	} req_beat_t;

	typedef struct packed {
		logic [31:0] bin;
		logic [31:0] total;
		logic        flag;
	} rsp_beat_t;

	logic clk;
	logic arst_n;

	bbh_req_if req_bus ();
	bbh_rsp_if rsp_bus ();
	bbh_cfg_if cfg_bus ();

	byte_bigram_histogram i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	// Shadow copy of the histogram state
	logic              primed    [CONTEXTS_DEF];
	logic [7:0]        last_byte [CONTEXTS_DEF];
	logic [31:0]       ctx_total [CONTEXTS_DEF];
	logic [31:0]       pair_hist [logic [17:0]];
	logic [31:0]       threshold = REPORT_RESET;

	req_beat_t stim_queue [$];
	rsp_beat_t tally_fifo [$];

	int unsigned n_queued    = 0;
	int unsigned n_accepted  = 0;
	int unsigned n_results   = 0;
	int unsigned n_records   = 0;
	int unsigned n_reads     = 0;
	int unsigned n_cfg       = 0;
	int unsigned n_errors    = 0;
	int unsigned quiet_count = 0;
	int unsigned gap_left    = 0;
	int unsigned pause_left  = 0;
	int unsigned hold_left   = 0;
	logic        held_once   = 1'b0;
	logic        calm        = 1'b0;
	logic        req_taken   = 1'b0;

	// Clock: 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Advance the shadow state by one request beat and return the result it owes
	function automatic rsp_beat_t bigram_step(input req_beat_t it);
		rsp_beat_t   r;
		int unsigned n;
		logic [7:0]  b;
		logic [17:0] slot;
		r = '0;
		if (it.ctx >= CONTEXTS_DEF)
			return r;
		if (it.op == OP_RECORD) begin
			n = (it.nbytes > BYTES_PER_ITEM_DEF) ? BYTES_PER_ITEM_DEF : it.nbytes;
			for (int i = 0; i < n; i++) begin
				b = it.data[8*i +: 8];
				// first byte of a context only primes the previous byte
				if (primed[it.ctx]) begin
					slot = {it.ctx, last_byte[it.ctx], b};
					if (!pair_hist.exists(slot))
						pair_hist[slot] = '0;
					if (pair_hist[slot] < BIN_MAX)
						pair_hist[slot] = pair_hist[slot] + 1;
				end
				primed[it.ctx] = 1'b1;
				last_byte[it.ctx] = b;
				if (ctx_total[it.ctx] != 32'hFFFF_FFFF)
					ctx_total[it.ctx] = ctx_total[it.ctx] + 1;
			end
		end else if (pair_hist.exists({it.ctx, it.key})) begin
			r.bin = pair_hist[{it.ctx, it.key}];
		end
		r.total = ctx_total[it.ctx];
		r.flag = (ctx_total[it.ctx] >= threshold);
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// Small alphabet so that bins collect counts above one
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'h41;
			2: return 8'h7E;
			default: return 8'hFF;
		endcase
	endfunction

	task automatic queue_item(input opcode_t op, input logic [1:0] ctx,
			input logic [3:0] nbytes, input logic [63:0] data, input logic [15:0] key);
		req_beat_t it;
		it.op = op;
		it.ctx = ctx;
		it.nbytes = nbytes;
		it.data = data;
		it.key = key;
		stim_queue.push_back(it);
		n_queued++;
	endtask

	task automatic queue_random_item();
		req_beat_t it;
		int unsigned sel;
		it.op = ($urandom_range(0, 99) < 55) ? OP_RECORD : OP_READ;
		it.ctx = 2'($urandom_range(0, 3));
		// mostly legal counts, a few empty and oversized ones
		sel = $urandom_range(0, 19);
		if (sel == 0)
			it.nbytes = 4'd0;
		else if (sel == 1)
			it.nbytes = 4'($urandom_range(9, 15));
		else
			it.nbytes = 4'($urandom_range(1, 8));
		if ($urandom_range(0, 1) == 0) begin
			it.data = {$urandom, $urandom};
		end else begin
			for (int i = 0; i < 8; i++)
				it.data[8*i +: 8] = pick_byte();
		end
		if ($urandom_range(0, 9) < 7)
			it.key = {pick_byte(), pick_byte()};
		else
			it.key = 16'($urandom_range(0, 16'hFFFF));
		stim_queue.push_back(it);
		n_queued++;
	endtask

	task automatic write_threshold(input logic [31:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= value;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (!(n_accepted == n_queued && tally_fifo.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Request driver: hold a beat until taken, insert random gaps
	always @(negedge clk) begin
		req_beat_t it;
		if (req_bus.valid && !req_taken) begin
			// hold the current beat
		end else if (gap_left > 0) begin
			gap_left--;
			req_bus.valid <= 1'b0;
		end else if (stim_queue.size() > 0 && !calm && $urandom_range(0, 4) == 0) begin
			gap_left = $urandom_range(0, 4);
			req_bus.valid <= 1'b0;
		end else if (stim_queue.size() > 0) begin
			it = stim_queue.pop_front();
			req_bus.opcode <= it.op;
			req_bus.context_req <= it.ctx;
			req_bus.byte_count <= it.nbytes;
			req_bus.data_bytes <= it.data;
			req_bus.bigram_key <= it.key;
			req_bus.valid <= 1'b1;
		end else begin
			req_bus.valid <= 1'b0;
		end
	end

	// Result sink: random stalls, plus one long hold to back up the block
	always @(negedge clk) begin
		logic go;
		go = 1'b1;
		if (hold_left > 0) begin
			hold_left--;
			go = 1'b0;
		end else if (!held_once && n_results >= 40) begin
			held_once = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			go = 1'b0;
		end else if (pause_left > 0) begin
			pause_left--;
			go = 1'b0;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			pause_left = $urandom_range(0, 4);
			go = 1'b0;
		end
		rsp_bus.ready <= go;
	end

	// Monitor: predict on each request beat, check each result beat
	always @(posedge clk) begin
		req_beat_t it;
		rsp_beat_t want;
		logic      busy;
		busy = 1'b0;
		req_taken <= req_bus.valid && req_bus.ready;
		if (cfg_bus.valid && cfg_bus.ready) begin
			threshold = cfg_bus.data;
			n_cfg++;
			busy = 1'b1;
		end
		if (req_bus.valid && req_bus.ready) begin
			it.op = req_bus.opcode;
			it.ctx = req_bus.context_req;
			it.nbytes = req_bus.byte_count;
			it.data = req_bus.data_bytes;
			it.key = req_bus.bigram_key;
			tally_fifo.push_back(bigram_step(it));
			if (it.op == OP_RECORD)
				n_records++;
			else
				n_reads++;
			n_accepted++;
			busy = 1'b1;
		end
		if (rsp_bus.valid && rsp_bus.ready) begin
			n_results++;
			busy = 1'b1;
			if (tally_fifo.size() == 0) begin
				flag_mismatch("result beat with nothing pending", rsp_bus.context_bytes, '0);
			end else begin
				want = tally_fifo.pop_front();
				if (rsp_bus.bigram_count !== want.bin)
					flag_mismatch("bigram_count", rsp_bus.bigram_count, want.bin);
				if (rsp_bus.context_bytes !== want.total)
					flag_mismatch("context_bytes", rsp_bus.context_bytes, want.total);
				if (rsp_bus.reportable !== want.flag)
					flag_mismatch("reportable", {31'd0, rsp_bus.reportable}, {31'd0, want.flag});
			end
		end
		quiet_count = busy ? 0 : quiet_count + 1;
	end

	// Watchdog: end the run if nothing moves for too long
	initial begin
		wait (quiet_count >= QUIET_LIMIT);
		$display("timeout after %0d quiet cycles", QUIET_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [31:0] top_total;
		for (int c = 0; c < CONTEXTS_DEF; c++) begin
			primed[c] = 1'b0;
			last_byte[c] = '0;
			ctx_total[c] = '0;
		end
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.opcode = OP_RECORD;
		req_bus.context_req = '0;
		req_bus.byte_count = '0;
		req_bus.data_bytes = '0;
		req_bus.bigram_key = '0;
		rsp_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed beats under the reset threshold
		queue_item(OP_READ,   2'd0, 4'd0,  64'd0, 16'h0000);
		queue_item(OP_RECORD, 2'd0, 4'd1,  64'h0000_0000_0000_00AB, 16'hFFFF);
		queue_item(OP_RECORD, 2'd0, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
		queue_item(OP_READ,   2'd0, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 16'hABFF);
		queue_item(OP_READ,   2'd0, 4'd0,  64'd0, 16'hFFFF);
		queue_item(OP_READ,   2'd0, 4'd0,  64'd0, 16'h00AB);
		queue_item(OP_RECORD, 2'd1, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
		queue_item(OP_READ,   2'd1, 4'd0,  64'd0, 16'hFF00);
		queue_item(OP_RECORD, 2'd1, 4'd15, 64'h0001_0203_0405_0607, 16'hFFFF);
		queue_item(OP_READ,   2'd1, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0706);
		queue_item(OP_READ,   2'd1, 4'd0,  64'd0, 16'h0100);
		queue_item(OP_RECORD, 2'd1, 4'd9,  64'd0, 16'h1234);
		queue_item(OP_READ,   2'd1, 4'd0,  64'd0, 16'h0000);
		queue_item(OP_READ,   2'd1, 4'd0,  64'd0, 16'h0000);
		queue_item(OP_RECORD, 2'd2, 4'd8,  64'h5555_5555_5555_5555, 16'h0000);
		queue_item(OP_RECORD, 2'd2, 4'd8,  64'h5555_5555_5555_5555, 16'h0000);
		queue_item(OP_READ,   2'd2, 4'd0,  64'd0, 16'h5555);
		queue_item(OP_RECORD, 2'd3, 4'd4,  64'hFFFF_FFFF_AAAA_AAAA, 16'hFFFF);
		queue_item(OP_READ,   2'd3, 4'd0,  64'd0, 16'hAAAA);
		queue_item(OP_READ,   2'd3, 4'd0,  64'd0, 16'hAAFF);
		queue_item(OP_READ,   2'd3, 4'd0,  64'd0, 16'hFFFF);
		queue_item(OP_RECORD, 2'd0, 4'd2,  64'h0000_0000_0000_FF00, 16'h0000);
		queue_item(OP_READ,   2'd0, 4'd0,  64'd0, 16'hFF00);
		queue_item(OP_READ,   2'd0, 4'd0,  64'd0, 16'h00FF);
		wait_idle();

		// Random phases across several thresholds
		write_threshold(REPORT_RESET);
		repeat (120) queue_random_item();
		wait_idle();

		write_threshold(32'd0);
		repeat (80) queue_random_item();
		wait_idle();

		write_threshold(32'hFFFF_FFFF);
		repeat (80) queue_random_item();
		wait_idle();

		// Place the threshold just above the busiest context, no idling from here
		top_total = '0;
		for (int c = 0; c < CONTEXTS_DEF; c++)
			if (ctx_total[c] > top_total)
				top_total = ctx_total[c];
		write_threshold(top_total + 32'd20);
		calm = 1'b1;
		repeat (100) queue_random_item();
		wait_idle();
		repeat (16) @(posedge clk);

		$display("Checked %0d results from %0d records and %0d reads over %0d threshold writes.",
			n_results, n_records, n_reads, n_cfg);
		$display("Bins touched: %0d; long result stall applied: %0d.", pair_hist.size(), held_once);
		if (n_errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
